// File: sv/ffsa_pkg.sv
// shared types and constants for the first-free slot allocator
`timescale 1ns / 1ps
`default_nettype none

package ffsa_pkg;

  // fixed field widths
  localparam int unsigned ID_W     = 6;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned LIMIT_W  = 7;

  // defaults for the top level parameters
  localparam int unsigned SLOTS_DEF       = 64;
  localparam int unsigned HANDLE_BITS_DEF = 32;

  // slot limit after reset
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd64;

  // request codes; OP_NOP also marks a request already refused at entry
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_GET   = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // result codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_NOSLOT = 2'd2,
    ST_BADID  = 2'd3
  } status_t;

  // request token that walks the row of cells
  typedef struct packed {
    logic                live;
    op_t                 op;
    status_t             status;
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
    logic                done;
    logic [ID_W-1:0]     rid;
    logic [HANDLE_W-1:0] hout;
  } tok_t;

endpackage

`default_nettype wire

// File: sv/ffsa_cell.sv
// one slot of the allocator: holds a handle and serves the passing token
`timescale 1ns / 1ps
`default_nettype none

module ffsa_cell import ffsa_pkg::*; #(
  parameter int unsigned IDX         = 0,
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [LIMIT_W-1:0] limit,
  input  wire tok_t               tok_i,
  output tok_t                    tok_o
);

  localparam int unsigned HW = HANDLE_BITS;

  // this slot's id as seen on the id and limit fields
  localparam bit                 ID_REACH  = (IDX < (1 << ID_W));
  localparam logic [ID_W-1:0]    MY_ID     = ID_W'(IDX % (1 << ID_W));
  localparam bit                 LIM_REACH = (IDX < (1 << LIMIT_W));
  localparam logic [LIMIT_W-1:0] MY_LIM    = LIMIT_W'(IDX % (1 << LIMIT_W));

  logic          occ_r, occ_nxt;
  logic [HW-1:0] hdl_r, hdl_nxt;
  tok_t          tok_r, tok_nxt;

  logic                    id_hit;
  logic                    below_lim;
  logic [HW+HANDLE_W-1:0]  in_wide;
  logic [HW-1:0]           stored;
  logic [HANDLE_W+HW-1:0]  out_wide;
  logic [HANDLE_W-1:0]     hdl_rd;

  // slot match and limit check
  assign id_hit    = ID_REACH && (tok_i.id == MY_ID);
  assign below_lim = LIM_REACH && (MY_LIM < limit);

  // fit the handle to the stored width and back
  assign in_wide  = {{HW{1'b0}}, tok_i.handle};
  assign stored   = in_wide[HW-1:0];
  assign out_wide = {{HANDLE_W{1'b0}}, hdl_r};
  assign hdl_rd   = occ_r ? out_wide[HANDLE_W-1:0] : '0;

  // act on the token as it passes
  always_comb begin
    tok_nxt = tok_i;
    occ_nxt = occ_r;
    hdl_nxt = hdl_r;
    if (tok_i.live) begin
      case (tok_i.op)
        OP_ALLOC: begin
          if (!tok_i.done && below_lim && !occ_r) begin
            hdl_nxt      = stored;
            occ_nxt      = |stored;
            tok_nxt.done = 1'b1;
            tok_nxt.rid  = MY_ID;
          end
        end
        OP_FREE: begin
          if (id_hit) begin
            occ_nxt = 1'b0;
          end
        end
        OP_GET: begin
          if (id_hit) begin
            tok_nxt.hout = hdl_rd;
            tok_nxt.done = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // occupancy and token
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      tok_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      tok_r <= tok_nxt;
    end
  end

  // stored handle
  always_ff @(posedge clk) begin
    hdl_r <= hdl_nxt;
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

// File: sv/first_free_slot_allocator.sv
// top level of the first-free slot allocator: entry checks, cell row, result
//
// usage
//   commands: drive in_opcode, in_slot_id, in_handle with start high; the
//   beat is taken at a rising edge where start is high and busy is low.
//   opcodes: allocate, free, get handle.
//   results: out_valid is high for exactly one cycle with out_status,
//   out_result_id and out_handle_out; the receiver cannot stall, so the
//   result is gone after that cycle.
//   configuration: cfg_we with cfg_wdata writes slot_limit at any edge;
//   write it only while busy is low.
// timing
//   a command walks a row of SLOTS cells, one cell per cycle, and the
//   result register follows the last cell: out_valid rises in the same
//   cycle that busy falls, so a new command is taken only after the
//   result of the last one.
// reset
//   rst_n (synchronous, low) empties every slot, zeroes the in-use count
//   and sets slot_limit to 64.
`timescale 1ns / 1ps
`default_nettype none

module first_free_slot_allocator import ffsa_pkg::*; #(
  parameter int unsigned SLOTS       = SLOTS_DEF,
  parameter int unsigned HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // command channel
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_opcode,
  input  wire logic [ID_W-1:0]     in_slot_id,
  input  wire logic [HANDLE_W-1:0] in_handle,
  // result channel
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic [ID_W-1:0]          out_result_id,
  output logic [HANDLE_W-1:0]      out_handle_out,
  // configuration
  input  wire logic                cfg_we,
  input  wire logic [LIMIT_W-1:0]  cfg_wdata
);

  localparam int unsigned LIM_MAX = (1 << LIMIT_W) - 1;
  localparam logic [LIMIT_W-1:0] CAP_LIM =
    LIMIT_W'((SLOTS > LIM_MAX) ? LIM_MAX : SLOTS);
  localparam bit ALL_IDS = (SLOTS >= (1 << ID_W));
  localparam logic [ID_W-1:0] ID_END = ID_W'(SLOTS % (1 << ID_W));

  logic [LIMIT_W-1:0] slot_limit_r;
  logic [LIMIT_W-1:0] count_r, count_nxt;
  logic               busy_r, busy_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [ID_W-1:0]    out_rid_r, out_rid_nxt;
  logic [HANDLE_W-1:0] out_hout_r, out_hout_nxt;

  logic               accept;
  logic [LIMIT_W-1:0] lim;
  tok_t               entry;
  tok_t               tail;
  tok_t               chain [SLOTS+1];

  assign accept = start && !busy_r;
  assign lim    = (slot_limit_r > CAP_LIM) ? CAP_LIM : slot_limit_r;

  // entry checks: refused commands travel as no-ops with their status
  always_comb begin
    entry        = '0;
    entry.live   = accept;
    entry.op     = op_t'(in_opcode);
    entry.status = ST_OK;
    entry.id     = in_slot_id;
    entry.handle = in_handle;
    case (op_t'(in_opcode))
      OP_ALLOC: begin
        if (count_r >= lim) begin
          entry.status = ST_FULL;
          entry.op     = OP_NOP;
        end
      end
      OP_FREE: begin
        if ({1'b0, in_slot_id} >= lim) begin
          entry.status = ST_BADID;
          entry.op     = OP_NOP;
        end
      end
      OP_GET: begin
        if (!ALL_IDS && (in_slot_id >= ID_END)) begin
          entry.status = ST_BADID;
          entry.op     = OP_NOP;
        end
      end
      default: begin
        entry.status = ST_BADID;
        entry.op     = OP_NOP;
      end
    endcase
  end

  // row of slot cells
  assign chain[0] = entry;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    ffsa_cell #(
      .IDX         (g),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .limit (slot_limit_r),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  assign tail = chain[SLOTS];

  // result, count and busy at the end of the row
  always_comb begin
    busy_nxt       = busy_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = tail.status;
    out_rid_nxt    = tail.rid;
    out_hout_nxt   = tail.hout;
    if (accept) begin
      busy_nxt = 1'b1;
    end
    if (tail.live) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      if (tail.op == OP_ALLOC) begin
        if (tail.done) begin
          count_nxt = count_r + 1'b1;
        end else begin
          out_status_nxt = ST_NOSLOT;
        end
      end else if (tail.op == OP_FREE) begin
        if (count_r != '0) begin
          count_nxt = count_r - 1'b1;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_limit_r <= LIMIT_RST;
      count_r      <= '0;
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        slot_limit_r <= cfg_wdata;
      end
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_rid_r    <= out_rid_nxt;
    out_hout_r   <= out_hout_nxt;
  end

  assign busy           = busy_r;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_result_id  = out_rid_r;
  assign out_handle_out = out_hout_r;

endmodule

`default_nettype wire

// File: sv/ffsa_checker.sv
// port-level checks for the first-free slot allocator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ffsa_checker import ffsa_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire logic [1:0]          out_status,
  input wire logic [ID_W-1:0]     out_result_id,
  input wire logic [HANDLE_W-1:0] out_handle_out
);

  // a taken command beat keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after a command beat");

  // a result only ever follows a command in flight
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a command in flight");

  // one strobe per command, never two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // failed requests carry no id and no handle
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |->
      ((out_result_id == '0) && (out_handle_out == '0)))
    else $error("failed request returned an id or a handle");

endmodule

bind first_free_slot_allocator ffsa_checker u_ffsa_checker (.*);

`default_nettype wire

// File: dv/first_free_slot_allocator_test.sv
// self-checking testbench for the first-free slot allocator
`timescale 1ns / 1ps

module first_free_slot_allocator_test;
  import ffsa_pkg::*;

  localparam int unsigned SLOT_COUNT = SLOTS_DEF;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RANDOM_ITEMS = 1000;

  // one expected result beat
  typedef struct {
    status_t             status;
    logic [ID_W-1:0]     rid;
    logic [HANDLE_W-1:0] hout;
  } slot_result_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [1:0]          in_opcode;
  logic [ID_W-1:0]     in_slot_id;
  logic [HANDLE_W-1:0] in_handle;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [ID_W-1:0]     out_result_id;
  logic [HANDLE_W-1:0] out_handle_out;
  logic                cfg_we;
  logic [LIMIT_W-1:0]  cfg_wdata;

  // predicted slot table
  logic [HANDLE_W-1:0] model_handle [SLOT_COUNT];
  logic [LIMIT_W-1:0]  model_count;
  logic [LIMIT_W-1:0]  model_limit;

  slot_result_t pending_results [$];
  int unsigned  mismatches;
  int unsigned  cycles;
  bit           no_gaps;

  first_free_slot_allocator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_slot_id    (in_slot_id),
    .in_handle     (in_handle),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_result_id (out_result_id),
    .out_handle_out(out_handle_out),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [HANDLE_W-1:0] want,
                                 input logic [HANDLE_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    end
  endtask

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    slot_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", '0, HANDLE_W'(out_status));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", HANDLE_W'(want.status), HANDLE_W'(out_status));
        if (out_result_id !== want.rid)
          report_mismatch("result_id", HANDLE_W'(want.rid), HANDLE_W'(out_result_id));
        if (out_handle_out !== want.hout) report_mismatch("handle_out", want.hout, out_handle_out);
      end
    end
  end

  // predicted outcome of one command, updating the table
  function automatic slot_result_t apply_slot_command(input op_t op,
                                                      input logic [ID_W-1:0] id,
                                                      input logic [HANDLE_W-1:0] h);
    slot_result_t r;
    int unsigned  lim;
    bit           hit;
    r.status = ST_OK;
    r.rid = '0;
    r.hout = '0;
    lim = (model_limit > SLOT_COUNT) ? SLOT_COUNT : model_limit;
    case (op)
      OP_ALLOC: begin
        if (model_count >= lim) begin
          r.status = ST_FULL;
        end else begin
          hit = 1'b0;
          for (int unsigned i = 0; i < lim && !hit; i++) begin
            if (model_handle[i] == '0) begin
              hit = 1'b1;
              r.rid = ID_W'(i);
            end
          end
          if (!hit) begin
            r.status = ST_NOSLOT;
          end else begin
            model_handle[r.rid] = h;
            model_count = model_count + 1'b1;
          end
        end
      end
      OP_FREE: begin
        if (id >= lim) begin
          r.status = ST_BADID;
        end else begin
          model_handle[id] = '0;
          if (model_count != 0) model_count = model_count - 1'b1;
        end
      end
      OP_GET: begin
        // every 6-bit id is inside the table
        r.hout = model_handle[id];
      end
      default: begin
        r.status = ST_BADID;
      end
    endcase
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(20, 4);
    return $urandom_range(150, 40);
  endfunction

  // random occupied slot below the active limit; id kept when none is taken
  function automatic bit pick_busy_slot(inout logic [ID_W-1:0] id);
    int unsigned lim;
    int unsigned taken [$];
    lim = (model_limit > SLOT_COUNT) ? SLOT_COUNT : model_limit;
    for (int unsigned i = 0; i < lim; i++) begin
      if (model_handle[i] != '0) taken.push_back(i);
    end
    if (taken.size() == 0) return 1'b0;
    id = ID_W'(taken[$urandom_range(taken.size() - 1)]);
    return 1'b1;
  endfunction

  // send one command beat and record its prediction once taken
  task automatic send_cmd(input op_t op, input logic [ID_W-1:0] id,
                          input logic [HANDLE_W-1:0] h);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      if (start) start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_opcode  <= op;
    in_slot_id <= id;
    in_handle  <= h;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_results.push_back(apply_slot_command(op, id, h));
  endtask

  // hold off until every predicted beat has come back
  task automatic wait_for_results();
    if (start) begin
      start <= 1'b0;
      @(posedge clk);
    end
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // slot limit write, only with the block idle
  task automatic write_slot_limit(input logic [LIMIT_W-1:0] value);
    wait_for_results();
    while (busy !== 1'b0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    model_limit = value;
  endtask

  // allocate extremes, zero handle reuse, get, unused opcode
  task automatic test_basic_commands();
    send_cmd(OP_ALLOC, 6'd63, 32'hFFFF_FFFF);
    send_cmd(OP_ALLOC, 6'd0, 32'h0);
    send_cmd(OP_ALLOC, 6'd17, 32'h1);
    send_cmd(OP_GET, 6'd0, 32'hFFFF_FFFF);
    send_cmd(OP_GET, 6'd63, 32'h0);
    send_cmd(OP_FREE, 6'd0, 32'h0);
    send_cmd(OP_NOP, 6'd63, 32'hFFFF_FFFF);
  endtask

  // free of an empty slot and count holding at zero
  task automatic test_free_corners();
    send_cmd(OP_FREE, 6'd0, 32'h0);
    send_cmd(OP_FREE, 6'd1, 32'h0);
    send_cmd(OP_FREE, 6'd5, 32'hDEAD_BEEF);
  endtask

  // zero limit, limit above table size, full, no slot, limit below count
  task automatic test_limit_corners();
    write_slot_limit(7'd0);
    send_cmd(OP_ALLOC, 6'd0, 32'h1234_5678);
    send_cmd(OP_FREE, 6'd0, 32'h0);
    write_slot_limit(7'd127);
    send_cmd(OP_FREE, 6'd63, 32'h0);
    send_cmd(OP_ALLOC, 6'd0, 32'hA5A5_A5A5);
    write_slot_limit(7'd2);
    send_cmd(OP_ALLOC, 6'd0, 32'h2);
    send_cmd(OP_ALLOC, 6'd0, 32'h8000_0000);
    send_cmd(OP_FREE, 6'd1, 32'h0);
    send_cmd(OP_FREE, 6'd1, 32'h0);
    send_cmd(OP_ALLOC, 6'd0, 32'h3);
    send_cmd(OP_ALLOC, 6'd0, 32'h4);
    write_slot_limit(7'd1);
    send_cmd(OP_ALLOC, 6'd0, 32'h5);
    send_cmd(OP_FREE, 6'd1, 32'h0);
    send_cmd(OP_FREE, 6'd0, 32'h0);
    send_cmd(OP_ALLOC, 6'd0, 32'h5);
  endtask

  // phases of random traffic under changing limits
  task automatic test_random_traffic();
    int unsigned         sent;
    int unsigned         phase;
    int unsigned         phase_len;
    int unsigned         r;
    logic [LIMIT_W-1:0]  lim;
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] h;
    op_t                 op;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      // extremes first, then random limits leaning small
      case (phase)
        0: lim = 7'd1;
        1: lim = 7'd64;
        2: lim = 7'd0;
        3: lim = 7'd127;
        default: begin
          r = $urandom_range(9);
          if (r < 2) lim = LIMIT_W'($urandom_range(3, 1));
          else if (r < 7) lim = LIMIT_W'($urandom_range(64, 1));
          else lim = LIMIT_W'($urandom_range(127, 0));
        end
      endcase
      write_slot_limit(lim);
      no_gaps = ($urandom_range(3) == 0);
      phase_len = (lim > 8) ? $urandom_range(150, 60) : $urandom_range(60, 20);
      for (int unsigned k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        // sender pause until the table is quiet
        if ($urandom_range(39) == 0) wait_for_results();
        id = ID_W'($urandom_range(63));
        h = '0;
        r = $urandom_range(99);
        if (r < 45) begin
          op = OP_ALLOC;
          r = $urandom_range(99);
          if (r < 88) begin
            do h = $urandom(); while (h == '0);
          end else if (r < 94) begin
            h = '0;
          end else if (r < 97) begin
            h = 32'hFFFF_FFFF;
          end else begin
            h = 32'h1 << $urandom_range(31);
          end
        end else if (r < 75) begin
          op = OP_FREE;
          if ($urandom_range(9) < 7) void'(pick_busy_slot(id));
          h = $urandom();
        end else if (r < 95) begin
          op = OP_GET;
          if ($urandom_range(9) < 6) void'(pick_busy_slot(id));
          h = $urandom();
        end else begin
          op = OP_NOP;
          h = $urandom();
        end
        send_cmd(op, id, h);
        sent++;
      end
      phase++;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_opcode  = OP_ALLOC;
    in_slot_id = '0;
    in_handle  = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    mismatches = 0;
    cycles     = 0;
    no_gaps    = 1'b0;
    foreach (model_handle[i]) model_handle[i] = '0;
    model_count = '0;
    model_limit = LIMIT_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_commands();
    test_free_corners();
    test_limit_corners();
    test_random_traffic();

    // drain, then allow one full command time for stray beats
    wait_for_results();
    repeat (SLOT_COUNT + 8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/ffsa_pkg.sv
sv/ffsa_cell.sv
sv/first_free_slot_allocator.sv
sv/ffsa_checker.sv
dv/first_free_slot_allocator_test.sv
